/* rtl/qrs_pkg.sv */
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  localparam int STATUS_W    = 3;
  localparam int ROOT_W      = 34;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [STATUS_W-1:0] {
    ST_ZERO    = 3'd0,  // all coefficients zero, end-of-list marker
    ST_LINEAR  = 3'd1,  // a is zero
    ST_NO_REAL = 3'd2,  // negative discriminant
    ST_DOUBLE  = 3'd3,  // one double root
    ST_TWO     = 3'd4   // two distinct roots
  } status_t;

endpackage

/* rtl/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front end, queue and back end.
//
// Usage:
//  - in_* channel: one request per equation, coefficients a, b, c as signed
//    COEF_WIDTH-bit integers. A request is taken when in_tvalid and in_tready
//    are both high at a rising edge of clk.
//  - out_* channel: one result per request, in request order: status code,
//    first and second root as signed Q17.16 (FRAC_BITS fraction bits).
//  - Throughput: one request per cycle, sustained, when out_tready stays high.
//  - Pipeline: the first front stage loads at the accepting edge, then
//    1 front stage + 1 queue slot + (COEF_WIDTH+FRAC_BITS+2) square root
//    stages + 1 numerator stage + (COEF_WIDTH+FRAC_BITS+3) divider stages
//    + 1 output register lie before out_tvalid rises. The square root and
//    divider pipelines make up the longest part of this path.
//  - A 4-entry queue sits between front and back. When out_tready is low and
//    out_tvalid is high the back end holds, the queue fills, and in_tready
//    drops while the queue is full and a request waits in the last front
//    stage; nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) empties every stage and the queue;
//    out_tvalid is low on the first cycle after reset.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // coef_a, coef_b, coef_c, zero padding
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[2:0], root_first[36:3], root_second[70:37], zero padding
  output logic [qrs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int W   = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int IW  = qrs_pkg::STATUS_W + (2*W + 1) + (W + F + 1) + (W + 1);
  localparam int RTW = qrs_pkg::ROOT_W;

  logic                push, pop, q_full, q_empty;
  qrs_pkg::status_t    f_st, b_st, o_st;
  logic [2*W:0]        f_d, b_d;
  logic signed [W+F:0] f_nb, b_nb;
  logic signed [W:0]   f_den, b_den;
  logic [IW-1:0]       q_wdata, q_rdata;
  logic [RTW-1:0]      o_r1, o_r2;

  qrs_front #(.W(W), .F(F)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .coef_a   ($signed(in_tdata[W-1:0])),
    .coef_b   ($signed(in_tdata[2*W-1:W])),
    .coef_c   ($signed(in_tdata[3*W-1:2*W])),
    .q_full   (q_full),
    .push     (push),
    .item_st  (f_st),
    .item_d   (f_d),
    .item_nb  (f_nb),
    .item_den (f_den)
  );

  assign q_wdata = {f_den, f_nb, f_d, f_st};

  qrs_queue #(.WIDTH(IW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_st  = qrs_pkg::status_t'(q_rdata[qrs_pkg::STATUS_W-1:0]);
  assign b_d   = q_rdata[qrs_pkg::STATUS_W +: 2*W+1];
  assign b_nb  = $signed(q_rdata[qrs_pkg::STATUS_W + 2*W + 1 +: W+F+1]);
  assign b_den = $signed(q_rdata[IW-1 -: W+1]);

  qrs_back #(.W(W), .F(F)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (!q_empty),
    .pop             (pop),
    .item_st         (b_st),
    .item_d          (b_d),
    .item_nb         (b_nb),
    .item_den        (b_den),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (o_st),
    .out_root_first  (o_r1),
    .out_root_second (o_r2)
  );

  assign out_tdata = {{(qrs_pkg::OUT_TDATA_W - qrs_pkg::STATUS_W - 2*RTW){1'b0}},
                      o_r2, o_r1, o_st};

endmodule

/* rtl/qrs_front.sv */
// Front end: takes coefficients, forms the discriminant and classifies the equation.
module qrs_front #(
  parameter int W = 16,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [W-1:0]     coef_a,
  input  logic signed [W-1:0]     coef_b,
  input  logic signed [W-1:0]     coef_c,
  input  logic                    q_full,
  output logic                    push,
  output qrs_pkg::status_t        item_st,
  output logic [2*W:0]            item_d,
  output logic signed [W+F:0]     item_nb,
  output logic signed [W:0]       item_den
);

  logic                   en;
  logic                   s1_v_r;
  logic signed [2*W-1:0]  s1_bb_r;
  logic signed [2*W-1:0]  s1_ac_r;
  logic signed [W-1:0]    s1_a_r;
  logic signed [W-1:0]    s1_b_r;
  logic                   s1_cz_r;

  logic                   s2_v_r;
  qrs_pkg::status_t       s2_st_r,  s2_st_nxt;
  logic [2*W:0]           s2_d_r,   s2_d_nxt;
  logic signed [W+F:0]    s2_nb_r,  s2_nb_nxt;
  logic signed [W:0]      s2_den_r, s2_den_nxt;
  logic signed [2*W+1:0]  disc;

  assign en       = !(s2_v_r && q_full);
  assign in_ready = en;
  assign push     = s2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb_r  <= coef_b * coef_b;
      s1_ac_r  <= coef_a * coef_c;
      s1_a_r   <= coef_a;
      s1_b_r   <= coef_b;
      s1_cz_r  <= (coef_c == '0);
      s2_st_r  <= s2_st_nxt;
      s2_d_r   <= s2_d_nxt;
      s2_nb_r  <= s2_nb_nxt;
      s2_den_r <= s2_den_nxt;
    end
  end

  always_comb begin
    disc = {{2{s1_bb_r[2*W-1]}}, s1_bb_r} - ({{2{s1_ac_r[2*W-1]}}, s1_ac_r} <<< 2);
    if (s1_a_r == '0 && s1_b_r == '0 && s1_cz_r) begin
      s2_st_nxt = qrs_pkg::ST_ZERO;
    end else if (s1_a_r == '0) begin
      s2_st_nxt = qrs_pkg::ST_LINEAR;
    end else if (disc[2*W+1]) begin
      s2_st_nxt = qrs_pkg::ST_NO_REAL;
    end else if (disc == '0) begin
      s2_st_nxt = qrs_pkg::ST_DOUBLE;
    end else begin
      s2_st_nxt = qrs_pkg::ST_TWO;
    end
    // only a positive discriminant goes to the square root
    s2_d_nxt   = (s2_st_nxt == qrs_pkg::ST_TWO) ? disc[2*W:0] : '0;
    s2_nb_nxt  = -($signed({{(F+1){s1_b_r[W-1]}}, s1_b_r}) <<< F);
    s2_den_nxt = {s1_a_r, 1'b0};
  end

  assign item_st  = s2_st_r;
  assign item_d   = s2_d_r;
  assign item_nb  = s2_nb_r;
  assign item_den = s2_den_r;

endmodule

/* rtl/qrs_queue.sv */
// Small register FIFO between the front end and the back end.
module qrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/qrs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module qrs_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic signed [NW:0]   num,
  input  logic signed [DW-1:0] den,
  output logic [NW-1:0]     quo,
  output logic              neg
);

  logic [NW-1:0] n_r   [0:NW];
  logic [NW-1:0] q_r   [0:NW];
  logic [DW-1:0] rem_r [0:NW];
  logic [DW-1:0] dv_r  [0:NW];
  logic          sg_r  [0:NW];
  logic [NW:0]   num_mag;
  logic [DW-1:0] den_mag;

  assign num_mag = num[NW] ? (NW+1)'(0) - num : num;
  assign den_mag = den[DW-1] ? DW'(0) - den : den;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= num_mag[NW-1:0];
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      dv_r[0]  <= den_mag;
      sg_r[0]  <= num[NW] ^ den[DW-1];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] r2;
    logic        ge;
    logic [DW:0] diff;
    assign r2   = {rem_r[k], n_r[k][NW-1]};
    assign ge   = (r2 >= {1'b0, dv_r[k]});
    assign diff = r2 - {1'b0, dv_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]   <= n_r[k] << 1;
        q_r[k+1]   <= {q_r[k][NW-2:0], ge};
        rem_r[k+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        dv_r[k+1]  <= dv_r[k];
        sg_r[k+1]  <= sg_r[k];
      end
    end
  end

  assign quo = q_r[NW];
  assign neg = sg_r[NW];

endmodule

/* rtl/qrs_back.sv */
// Back end: pipelined square root, two dividers, saturation and output register.
module qrs_back #(
  parameter int W = 16,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                pop,
  input  qrs_pkg::status_t    item_st,
  input  logic [2*W:0]        item_d,
  input  logic signed [W+F:0] item_nb,
  input  logic signed [W:0]   item_den,
  output logic                out_valid,
  input  logic                out_ready,
  output qrs_pkg::status_t    out_status,
  output logic [qrs_pkg::ROOT_W-1:0] out_root_first,
  output logic [qrs_pkg::ROOT_W-1:0] out_root_second
);

  localparam int S   = W + F + 1;       // square root bits
  localparam int XW  = 2 * S;           // radicand bits
  localparam int RW  = S + 3;           // remainder bits
  localparam int NW  = W + F + 2;       // numerator magnitude bits
  localparam int L   = NW + 1;          // divider stages
  localparam int RTW = qrs_pkg::ROOT_W;
  localparam int EW  = (NW + 1 > RTW + 1) ? NW + 1 : RTW + 1;
  localparam logic signed [EW-1:0] RMAX = $signed({{(EW-RTW+1){1'b0}}, {(RTW-1){1'b1}}});
  localparam logic signed [EW-1:0] RMIN = $signed({{(EW-RTW+1){1'b1}}, {(RTW-1){1'b0}}});

  logic en;

  logic                sq_v_r   [0:S];
  qrs_pkg::status_t    sq_st_r  [0:S];
  logic [RW-1:0]       sq_rem_r [0:S];
  logic [S-1:0]        sq_root_r[0:S];
  logic [XW-1:0]       sq_x_r   [0:S];
  logic signed [W+F:0] sq_nb_r  [0:S];
  logic signed [W:0]   sq_den_r [0:S];

  logic                p_v_r;
  qrs_pkg::status_t    p_st_r;
  logic signed [NW:0]  p_n1_r, p_n1_nxt;
  logic signed [NW:0]  p_n2_r, p_n2_nxt;
  logic signed [W:0]   p_den_r;

  logic                dl_v_r  [0:L-1];
  qrs_pkg::status_t    dl_st_r [0:L-1];

  logic [NW-1:0]       q1, q2;
  logic                neg1, neg2;

  logic                out_v_r;
  qrs_pkg::status_t    out_st_r;
  logic [RTW-1:0]      r1_r, r1_nxt;
  logic [RTW-1:0]      r2_r, r2_nxt;

  function automatic logic [RTW-1:0] sat_root(input logic [NW-1:0] q, input logic ng);
    logic signed [EW-1:0] v;
    v = ng ? -$signed(EW'(q)) : $signed(EW'(q));
    if (v > RMAX) begin
      v = RMAX;
    end else if (v < RMIN) begin
      v = RMIN;
    end
    return v[RTW-1:0];
  endfunction

  assign en  = !out_v_r || out_ready;
  assign pop = en && in_valid;

  // square root stage 0 loads from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_st_r[0]   <= item_st;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0]    <= XW'(item_d) << (2 * F);
      sq_nb_r[0]   <= item_nb;
      sq_den_r[0]  <= item_den;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_sqrt
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    assign rem_sh = {sq_rem_r[k][RW-3:0], sq_x_r[k][XW-1:XW-2]};
    assign trial  = RW'({sq_root_r[k], 2'b01});
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][S-2:0], ge};
        sq_x_r[k+1]    <= sq_x_r[k] << 2;
        sq_st_r[k+1]   <= sq_st_r[k];
        sq_nb_r[k+1]   <= sq_nb_r[k];
        sq_den_r[k+1]  <= sq_den_r[k];
      end
    end
  end

  // numerators -b*2^F -/+ sqrt(d)*2^F
  assign p_n1_nxt = {{2{sq_nb_r[S][W+F]}}, sq_nb_r[S]} - $signed({2'b00, sq_root_r[S]});
  assign p_n2_nxt = {{2{sq_nb_r[S][W+F]}}, sq_nb_r[S]} + $signed({2'b00, sq_root_r[S]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v_r[S];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_st_r  <= sq_st_r[S];
      p_n1_r  <= p_n1_nxt;
      p_n2_r  <= p_n2_nxt;
      p_den_r <= sq_den_r[S];
    end
  end

  qrs_div #(.NW(NW), .DW(W + 1)) u_div_first (
    .clk (clk), .en (en), .num (p_n1_r), .den (p_den_r), .quo (q1), .neg (neg1)
  );

  qrs_div #(.NW(NW), .DW(W + 1)) u_div_second (
    .clk (clk), .en (en), .num (p_n2_r), .den (p_den_r), .quo (q2), .neg (neg2)
  );

  // status and valid ride alongside the dividers
  for (genvar k = 0; k < L; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_v_r[k] <= 1'b0;
      end else if (en) begin
        dl_v_r[k] <= (k == 0) ? p_v_r : dl_v_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dl_st_r[k] <= (k == 0) ? p_st_r : dl_st_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    r1_nxt = '0;
    r2_nxt = '0;
    case (dl_st_r[L-1])
      qrs_pkg::ST_TWO: begin
        r1_nxt = sat_root(q1, neg1);
        r2_nxt = sat_root(q2, neg2);
      end
      qrs_pkg::ST_DOUBLE: begin
        r1_nxt = sat_root(q1, neg1);
      end
      default: begin
        r1_nxt = '0;
        r2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dl_v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= dl_st_r[L-1];
      r1_r     <= r1_nxt;
      r2_r     <= r2_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_st_r;
  assign out_root_first  = r1_r;
  assign out_root_second = r2_r;

endmodule

/* rtl/qrs_check.sv */
// Port-level checks for the quadratic root solver, bound to the top level.
module qrs_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("status code out of range");

  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == 3'd0 || out_tdata[2:0] == 3'd1 ||
                   out_tdata[2:0] == 3'd2) |-> out_tdata[70:3] == '0)
    else $error("roots nonzero with no real root");

  a_double_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd3 |-> out_tdata[70:37] == '0)
    else $error("second root nonzero for double root");

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
